// ----- sv/pdlc_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pdlc_pkg
// Shared types, codes and reset values for the combination lock controller.
// ---------------------------------------------------------------------------
package pdlc_pkg;

  // default password length in bytes
  localparam int PASS_LEN_DEF = 5;

  // menu keys
  localparam logic [7:0] KEY_OPEN   = 8'h2B;
  localparam logic [7:0] KEY_CHANGE = 8'h2D;

  // register reset values
  localparam logic [7:0] OPEN_TICKS_RST  = 8'd15;
  localparam logic [7:0] HOLD_TICKS_RST  = 8'd3;
  localparam logic [7:0] CLOSE_TICKS_RST = 8'd15;
  localparam logic [7:0] ALARM_TICKS_RST = 8'd60;
  localparam logic [1:0] MAX_RETRIES_RST = 2'd2;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_OPEN_TICKS  = 3'd0,
    REG_HOLD_TICKS  = 3'd1,
    REG_CLOSE_TICKS = 3'd2,
    REG_ALARM_TICKS = 3'd3,
    REG_MAX_RETRIES = 3'd4
  } reg_index_t;

  // item kinds
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  // requested action after a good check
  typedef enum logic {
    ACT_OPEN   = 1'b0,
    ACT_CHANGE = 1'b1
  } action_t;

  // motor drive codes
  typedef enum logic [1:0] {
    MOTOR_STOP  = 2'd0,
    MOTOR_OPEN  = 2'd1,
    MOTOR_CLOSE = 2'd2
  } motor_t;

  // controller phases, one-hot
  typedef enum logic [7:0] {
    PH_NEW1  = 8'b0000_0001,
    PH_NEW2  = 8'b0000_0010,
    PH_MENU  = 8'b0000_0100,
    PH_CHECK = 8'b0000_1000,
    PH_OPEN  = 8'b0001_0000,
    PH_HOLD  = 8'b0010_0000,
    PH_CLOSE = 8'b0100_0000,
    PH_ALARM = 8'b1000_0000
  } phase_t;

  // configuration register set
  typedef struct packed {
    logic [7:0] open_ticks;
    logic [7:0] hold_ticks;
    logic [7:0] close_ticks;
    logic [7:0] alarm_ticks;
    logic [1:0] max_retries;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic   reply_valid;
    logic   reply_flag;
    motor_t motor_drive;
    logic   buzzer;
  } result_t;

  // enter a timed phase, falling through any segment of zero length
  function automatic phase_t enter_timed(input phase_t ph, input cfg_t cfg);
    phase_t p;
    p = ph;
    if (p == PH_OPEN && cfg.open_ticks == 8'd0) p = PH_HOLD;
    if (p == PH_HOLD && cfg.hold_ticks == 8'd0) p = PH_CLOSE;
    if (p == PH_CLOSE && cfg.close_ticks == 8'd0) p = PH_MENU;
    if (p == PH_ALARM && cfg.alarm_ticks == 8'd0) p = PH_MENU;
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- sv/pdlc_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pdlc_core
// Lock state machine: password entry, checking, retries, motor and alarm
// timing. Advances by one item when step is high and gives that item's result.
// ---------------------------------------------------------------------------
module pdlc_core
  import pdlc_pkg::*;
#(
  parameter int PASS_LEN = PASS_LEN_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         step,
  input  wire         opcode,
  input  wire  [7:0]  rx_byte,
  input  cfg_t        cfg,
  output result_t     res
);

  localparam int POS_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PASS_LEN - 1);

  // state registers
  phase_t           phase;
  logic [POS_W-1:0] byte_position;
  logic             mismatch_seen;
  action_t          pending_action;
  logic [1:0]       error_count;
  logic [7:0]       tick_count;
  logic [7:0]       first_entry     [PASS_LEN];
  logic [7:0]       stored_password [PASS_LEN];

  phase_t           phase_next;
  logic [POS_W-1:0] byte_position_next;
  logic             mismatch_seen_next;
  action_t          pending_action_next;
  logic [1:0]       error_count_next;
  logic [7:0]       tick_count_next;

  logic       wr_first;
  logic       copy_pw;
  logic       last;
  logic       mis_new;
  logic       mis_chk;
  logic [7:0] tick_inc;
  logic [7:0] dur;
  logic       rv;
  logic       rf;

  assign last     = (byte_position == LAST_POS);
  assign mis_new  = mismatch_seen | (first_entry[byte_position] != rx_byte);
  assign mis_chk  = mismatch_seen | (stored_password[byte_position] != rx_byte);
  assign tick_inc = tick_count + 8'd1;

  // length of the running timed segment
  always_comb begin
    case (phase)
      PH_OPEN:  dur = cfg.open_ticks;
      PH_HOLD:  dur = cfg.hold_ticks;
      PH_CLOSE: dur = cfg.close_ticks;
      default:  dur = cfg.alarm_ticks;
    endcase
  end

  // next state for one item
  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    mismatch_seen_next  = mismatch_seen;
    pending_action_next = pending_action;
    error_count_next    = error_count;
    tick_count_next     = tick_count;
    wr_first            = 1'b0;
    copy_pw             = 1'b0;
    rv                  = 1'b0;
    rf                  = 1'b0;

    if (opcode == OP_TICK) begin
      // ticks only matter in the timed phases
      if (phase == PH_OPEN || phase == PH_HOLD || phase == PH_CLOSE ||
          phase == PH_ALARM) begin
        tick_count_next = tick_inc;
        if (tick_inc >= dur) begin
          tick_count_next = 8'd0;
          case (phase)
            PH_OPEN: phase_next = enter_timed(PH_HOLD, cfg);
            PH_HOLD: phase_next = enter_timed(PH_CLOSE, cfg);
            default: phase_next = PH_MENU;
          endcase
        end
      end
    end else begin
      case (phase)
        PH_NEW1: begin
          wr_first = 1'b1;
          if (last) begin
            phase_next         = PH_NEW2;
            byte_position_next = '0;
            mismatch_seen_next = 1'b0;
          end else begin
            byte_position_next = byte_position + POS_W'(1);
          end
        end
        PH_NEW2: begin
          mismatch_seen_next = mis_new;
          if (last) begin
            rv                 = 1'b1;
            rf                 = !mis_new;
            byte_position_next = '0;
            mismatch_seen_next = 1'b0;
            if (!mis_new) begin
              copy_pw    = 1'b1;
              phase_next = PH_MENU;
            end else begin
              phase_next = PH_NEW1;
            end
          end else begin
            byte_position_next = byte_position + POS_W'(1);
          end
        end
        PH_MENU: begin
          if (rx_byte == KEY_OPEN || rx_byte == KEY_CHANGE) begin
            pending_action_next = (rx_byte == KEY_OPEN) ? ACT_OPEN : ACT_CHANGE;
            phase_next          = PH_CHECK;
            byte_position_next  = '0;
            mismatch_seen_next  = 1'b0;
          end
        end
        PH_CHECK: begin
          mismatch_seen_next = mis_chk;
          if (last) begin
            rv                 = 1'b1;
            rf                 = !mis_chk;
            byte_position_next = '0;
            mismatch_seen_next = 1'b0;
            if (!mis_chk) begin
              error_count_next = 2'd0;
              if (pending_action == ACT_OPEN) begin
                tick_count_next = 8'd0;
                phase_next      = enter_timed(PH_OPEN, cfg);
              end else begin
                phase_next = PH_NEW1;
              end
            end else if (error_count < cfg.max_retries) begin
              error_count_next = error_count + 2'd1;
              phase_next       = PH_CHECK;
            end else begin
              error_count_next = 2'd0;
              tick_count_next  = 8'd0;
              phase_next       = enter_timed(PH_ALARM, cfg);
            end
          end else begin
            byte_position_next = byte_position + POS_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result as it stands after the item
  always_comb begin
    res.reply_valid = rv;
    res.reply_flag  = rf;
    case (phase_next)
      PH_OPEN:  res.motor_drive = MOTOR_OPEN;
      PH_CLOSE: res.motor_drive = MOTOR_CLOSE;
      default:  res.motor_drive = MOTOR_STOP;
    endcase
    res.buzzer = (phase_next == PH_ALARM);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_NEW1;
      byte_position  <= '0;
      mismatch_seen  <= 1'b0;
      pending_action <= ACT_OPEN;
      error_count    <= 2'd0;
      tick_count     <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      mismatch_seen  <= mismatch_seen_next;
      pending_action <= pending_action_next;
      error_count    <= error_count_next;
      tick_count     <= tick_count_next;
    end
  end

  // password stores
  always_ff @(posedge clk) begin
    if (step && wr_first) begin
      first_entry[byte_position] <= rx_byte;
    end
    if (step && copy_pw) begin
      stored_password <= first_entry;
    end
  end

endmodule
`default_nettype wire

// ----- sv/password_door_lock_controller_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// password_door_lock_controller_top
// Combination lock controller: password set-up and checking over received
// bytes, door motor sequence and alarm timed by tick items.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one item per beat: opcode 0 is a
// received byte in rx_byte, opcode 1 is one timer tick. Every input beat
// yields exactly one result beat on the output channel (out_valid/out_ready)
// with the reply flag, motor drive and buzzer as they stand after that item.
// The result is loaded into the output register at the accepting edge and
// can be taken from the next cycle on. Throughput is one item per cycle if
// not stalled; the state update is a single pass of compare and select logic.
// When the receiver stalls, the output register holds its beat and in_ready
// falls, so no item is lost; in_ready rises again in the cycle the beat is
// taken. Register writes on the cfg channel are taken every cycle; index 0
// open_ticks, 1 hold_ticks, 2 close_ticks, 3 alarm_ticks, 4 max_retries.
// Reset restores the register defaults, empties the output register and
// starts collecting a new password. The password stores are not cleared.
// ---------------------------------------------------------------------------
module password_door_lock_controller_top
  import pdlc_pkg::*;
#(
  parameter int PASS_LEN = PASS_LEN_DEF
) (
  input  wire        clk,
  input  wire        rst,
  // input items
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        opcode,
  input  wire  [7:0] rx_byte,
  // result items
  output logic       out_valid,
  input  wire        out_ready,
  output logic       reply_valid,
  output logic       reply_flag,
  output logic [1:0] motor_drive,
  output logic       buzzer,
  // register writes
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [2:0] cfg_index,
  input  wire  [7:0] cfg_data
);

  cfg_t    cfg;
  result_t res_next;
  result_t res;
  logic    in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_ticks  <= OPEN_TICKS_RST;
      cfg.hold_ticks  <= HOLD_TICKS_RST;
      cfg.close_ticks <= CLOSE_TICKS_RST;
      cfg.alarm_ticks <= ALARM_TICKS_RST;
      cfg.max_retries <= MAX_RETRIES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_OPEN_TICKS:  cfg.open_ticks  <= cfg_data;
        REG_HOLD_TICKS:  cfg.hold_ticks  <= cfg_data;
        REG_CLOSE_TICKS: cfg.close_ticks <= cfg_data;
        REG_ALARM_TICKS: cfg.alarm_ticks <= cfg_data;
        REG_MAX_RETRIES: cfg.max_retries <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // lock state machine
  pdlc_core #(
    .PASS_LEN (PASS_LEN)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (in_fire),
    .opcode  (opcode),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (res_next)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign reply_valid = res.reply_valid;
  assign reply_flag  = res.reply_flag;
  assign motor_drive = res.motor_drive;
  assign buzzer      = res.buzzer;

endmodule
`default_nettype wire

// ----- bench/password_door_lock_controller_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// password_door_lock_controller_top_tb
// Drives received bytes and timer ticks into the lock controller under random
// idling and back-pressure, predicts every result beat with a behavioural
// model of the lock, and compares each beat field by field. A short scripted
// sequence opens the run; randomised password, menu and door traffic follows
// across several register settings written while the block is idle.
// ---------------------------------------------------------------------------
module password_door_lock_controller_top_tb;
  import pdlc_pkg::*;

  localparam int PW_LEN         = PASS_LEN_DEF;
  localparam int PHASES         = 12;
  localparam int PER_PHASE      = 115;
  localparam int WATCHDOG_LIMIT = 1000;

  // scripted password: extremes and both menu keys as data
  localparam logic [7:0] DIR_PW [PW_LEN] = '{8'h00, 8'hFF, KEY_OPEN, KEY_CHANGE, 8'h80};

  // results that can be read straight off the behaviour
  localparam result_t QUIET        = '{1'b0, 1'b0, MOTOR_STOP, 1'b0};
  localparam result_t GOOD_REPLY   = '{1'b1, 1'b1, MOTOR_STOP, 1'b0};
  localparam result_t BAD_REPLY    = '{1'b1, 1'b0, MOTOR_STOP, 1'b0};
  localparam result_t OPEN_REPLY   = '{1'b1, 1'b1, MOTOR_OPEN, 1'b0};
  localparam result_t DOOR_OPENING = '{1'b0, 1'b0, MOTOR_OPEN, 1'b0};

  typedef struct packed {
    opcode_t    op;
    logic [7:0] data;
    logic       fixed;
    result_t    want;
  } lock_row_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic       opcode    = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       reply_valid;
  logic       reply_flag;
  logic [1:0] motor_drive;
  logic       buzzer;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [7:0] cfg_data  = 8'h00;

  // lock behaviour as the bench sees it
  cfg_t        lock_cfg;
  phase_t      lk_phase;
  int unsigned lk_pos;
  logic [7:0]  lk_first [PW_LEN];
  logic [7:0]  lk_saved [PW_LEN];
  bit          lk_miss;
  action_t     lk_action;
  logic [1:0]  lk_errors;
  logic [7:0]  lk_ticks;

  result_t   lock_results_due [$];
  lock_row_t script [$];
  int        bad_beats    = 0;
  int        quiet_cycles = 0;
  int        stall_left   = 0;
  bit        full_rate    = 1'b0;

  password_door_lock_controller_top #(
    .PASS_LEN(PW_LEN)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reply_valid(reply_valid),
    .reply_flag (reply_flag),
    .motor_drive(motor_drive),
    .buzzer     (buzzer),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (full_rate || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 11))
      0: return 8'h00;
      1: return 8'hFF;
      2: return KEY_OPEN;
      3: return KEY_CHANGE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic lock_row_t row(input opcode_t op, input logic [7:0] d, input logic fx,
                                    input result_t w);
    lock_row_t r;
    r.op    = op;
    r.data  = d;
    r.fixed = fx;
    r.want  = w;
    return r;
  endfunction

  function automatic bit is_timed(input phase_t p);
    case (p)
      PH_OPEN, PH_HOLD, PH_CLOSE, PH_ALARM: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] seg_length(input phase_t p);
    case (p)
      PH_OPEN:  return lock_cfg.open_ticks;
      PH_HOLD:  return lock_cfg.hold_ticks;
      PH_CLOSE: return lock_cfg.close_ticks;
      PH_ALARM: return lock_cfg.alarm_ticks;
      default:  return 8'd1;
    endcase
  endfunction

  function automatic phase_t next_seg(input phase_t p);
    case (p)
      PH_OPEN: return PH_HOLD;
      PH_HOLD: return PH_CLOSE;
      default: return PH_MENU;
    endcase
  endfunction

  // start a timed segment, passing straight over any of zero length
  function automatic void enter_segment(input phase_t p);
    phase_t q;
    q = p;
    lk_ticks = 8'd0;
    while (q != PH_MENU && seg_length(q) == 8'd0) q = next_seg(q);
    lk_phase = q;
  endfunction

  function automatic void begin_entry(input phase_t p);
    lk_phase = p;
    lk_pos   = 0;
    lk_miss  = 1'b0;
  endfunction

  // advance the lock by one item and return the beat it produces
  function automatic result_t next_lock_result(input opcode_t op, input logic [7:0] b);
    result_t r;
    bit      last;
    r    = QUIET;
    last = (lk_pos + 1 >= PW_LEN);
    if (op == OP_TICK) begin
      if (is_timed(lk_phase)) begin
        lk_ticks = lk_ticks + 8'd1;
        if (lk_ticks >= seg_length(lk_phase)) enter_segment(next_seg(lk_phase));
      end
    end else begin
      case (lk_phase)
        PH_NEW1: begin
          lk_first[lk_pos] = b;
          if (last) begin_entry(PH_NEW2);
          else lk_pos++;
        end
        PH_NEW2: begin
          if (lk_first[lk_pos] != b) lk_miss = 1'b1;
          if (last) begin
            r.reply_valid = 1'b1;
            r.reply_flag  = !lk_miss;
            if (!lk_miss) begin
              lk_saved = lk_first;
              begin_entry(PH_MENU);
            end else begin
              begin_entry(PH_NEW1);
            end
          end else begin
            lk_pos++;
          end
        end
        PH_MENU: begin
          if (b == KEY_OPEN) begin
            lk_action = ACT_OPEN;
            begin_entry(PH_CHECK);
          end else if (b == KEY_CHANGE) begin
            lk_action = ACT_CHANGE;
            begin_entry(PH_CHECK);
          end
        end
        PH_CHECK: begin
          if (lk_saved[lk_pos] != b) lk_miss = 1'b1;
          if (last) begin
            r.reply_valid = 1'b1;
            r.reply_flag  = !lk_miss;
            if (!lk_miss) begin
              lk_errors = 2'd0;
              if (lk_action == ACT_OPEN) enter_segment(PH_OPEN);
              else begin_entry(PH_NEW1);
            end else if (lk_errors < lock_cfg.max_retries) begin
              lk_errors = lk_errors + 2'd1;
              begin_entry(PH_CHECK);
            end else begin
              lk_errors = 2'd0;
              enter_segment(PH_ALARM);
            end
          end else begin
            lk_pos++;
          end
        end
        default: ;
      endcase
    end
    r.motor_drive = (lk_phase == PH_OPEN)  ? MOTOR_OPEN :
                    (lk_phase == PH_CLOSE) ? MOTOR_CLOSE : MOTOR_STOP;
    r.buzzer      = (lk_phase == PH_ALARM);
    return r;
  endfunction

  // one input beat; valid stays up across back-to-back items
  task automatic send_item(input opcode_t op, input logic [7:0] b, input bit fixed,
                           input result_t want);
    int      gap;
    result_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    rx_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = next_lock_result(op, b);
    lock_results_due.push_back(fixed ? want : predicted);
  endtask

  // one register write beat; valid stays up between writes
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_OPEN_TICKS:  lock_cfg.open_ticks  = d;
      REG_HOLD_TICKS:  lock_cfg.hold_ticks  = d;
      REG_CLOSE_TICKS: lock_cfg.close_ticks = d;
      REG_ALARM_TICKS: lock_cfg.alarm_ticks = d;
      REG_MAX_RETRIES: lock_cfg.max_retries = d[1:0];
      default: ;
    endcase
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!full_rate && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.reply_valid = reply_valid;
      got.reply_flag  = reply_flag;
      got.motor_drive = motor_t'(motor_drive);
      got.buzzer      = buzzer;
      if (lock_results_due.size() == 0) begin
        if (bad_beats < 10)
          $display("unexpected beat at %0t: rv=%0b rf=%0b motor=%0d buzz=%0b",
                   $realtime, got.reply_valid, got.reply_flag, got.motor_drive, got.buzzer);
        bad_beats++;
      end else begin
        exp_r = lock_results_due.pop_front();
        if (got !== exp_r) begin
          if (bad_beats < 10) begin
            $display("mismatch at %0t: expected rv=%0b rf=%0b motor=%0d buzz=%0b",
                     $realtime, exp_r.reply_valid, exp_r.reply_flag, exp_r.motor_drive,
                     exp_r.buzzer);
            $display("  got rv=%0b rf=%0b motor=%0d buzz=%0b",
                     got.reply_valid, got.reply_flag, got.motor_drive, got.buzzer);
          end
          bad_beats++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] durs [4];
    logic [1:0] retries;
    opcode_t    op;
    logic [7:0] b;
    int         effective;
    int         r;

    // reset state of the bench's own lock
    lock_cfg.open_ticks  = OPEN_TICKS_RST;
    lock_cfg.hold_ticks  = HOLD_TICKS_RST;
    lock_cfg.close_ticks = CLOSE_TICKS_RST;
    lock_cfg.alarm_ticks = ALARM_TICKS_RST;
    lock_cfg.max_retries = MAX_RETRIES_RST;
    foreach (lk_first[i]) begin
      lk_first[i] = 8'h00;
      lk_saved[i] = 8'h00;
    end
    lk_action = ACT_OPEN;
    lk_errors = 2'd0;
    lk_ticks  = 8'd0;
    begin_entry(PH_NEW1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // scripted opening: set-up, menu noise, a retried check, then open
    script = '{
      row(OP_TICK, 8'h00,      1'b1, QUIET),        // tick while collecting
      row(OP_BYTE, DIR_PW[0],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[1],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[2],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[3],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[4],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[0],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[1],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[2],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[3],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[4],  1'b1, GOOD_REPLY),   // both entries agree
      row(OP_TICK, 8'hFF,      1'b1, QUIET),        // tick in the menu
      row(OP_BYTE, 8'h55,      1'b1, QUIET),        // stray menu byte
      row(OP_BYTE, KEY_OPEN,   1'b1, QUIET),
      row(OP_BYTE, DIR_PW[0],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[1],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[2],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[3],  1'b1, QUIET),
      row(OP_BYTE, 8'h7F,      1'b1, BAD_REPLY),    // wrong entry, retried
      row(OP_BYTE, DIR_PW[0],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[1],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[2],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[3],  1'b1, QUIET),
      row(OP_BYTE, DIR_PW[4],  1'b1, OPEN_REPLY),   // door starts opening
      row(OP_BYTE, KEY_CHANGE, 1'b1, DOOR_OPENING), // byte ignored while opening
      row(OP_TICK, 8'h00,      1'b0, QUIET)
    };
    foreach (script[i]) send_item(script[i].op, script[i].data, script[i].fixed, script[i].want);

    for (int k = 0; k < PHASES; k++) begin
      if (k != 0) begin
        // let every result drain before touching the registers
        in_valid <= 1'b0;
        while (lock_results_due.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);

        case (k)
          1: begin
            foreach (durs[i]) durs[i] = 8'hFF;
            retries = 2'd3;
          end
          2: begin
            foreach (durs[i]) durs[i] = 8'h00;
            retries = 2'd0;
          end
          3: begin
            durs    = '{8'd1, 8'd0, 8'd1, 8'd1};
            retries = 2'd1;
          end
          default: begin
            foreach (durs[i]) begin
              r = $urandom_range(0, 9);
              durs[i] = (r == 0) ? 8'($urandom) : (r == 1) ? 8'd0 : 8'($urandom_range(1, 6));
            end
            retries = 2'($urandom);
          end
        endcase
        write_reg(REG_OPEN_TICKS,  durs[0]);
        write_reg(REG_HOLD_TICKS,  durs[1]);
        write_reg(REG_CLOSE_TICKS, durs[2]);
        write_reg(REG_ALARM_TICKS, durs[3]);
        write_reg(REG_MAX_RETRIES, {6'($urandom), retries});
        // unassigned indexes are accepted and dropped
        if (k == 1)
          for (int i = int'(REG_MAX_RETRIES) + 1; i < (1 << $bits(cfg_index)); i++)
            write_reg(3'(i), 8'($urandom));
        cfg_valid <= 1'b0;
        full_rate = ($urandom_range(0, 3) == 0);
      end

      // random traffic steered by where the lock stands
      effective = 0;
      while (effective < PER_PHASE) begin
        op = OP_BYTE;
        b  = rand_byte();
        case (lk_phase)
          PH_NEW1: begin
            if ($urandom_range(0, 19) == 0) op = OP_TICK;
          end
          PH_NEW2: begin
            if ($urandom_range(0, 19) == 0) op = OP_TICK;
            else if ($urandom_range(0, 19) != 0) b = lk_first[lk_pos];
          end
          PH_MENU: begin
            r = $urandom_range(0, 99);
            if (r < 40) b = KEY_OPEN;
            else if (r < 65) b = KEY_CHANGE;
            else if (r >= 85) op = OP_TICK;
          end
          PH_CHECK: begin
            if ($urandom_range(0, 19) == 0) op = OP_TICK;
            else if ($urandom_range(0, 14) != 0) b = lk_saved[lk_pos];
          end
          default: begin
            if ($urandom_range(0, 9) != 0) op = OP_TICK;
          end
        endcase
        if (op == OP_TICK ? is_timed(lk_phase) :
            (!is_timed(lk_phase) && (lk_phase != PH_MENU || b == KEY_OPEN || b == KEY_CHANGE)))
          effective++;
        send_item(op, b, 1'b0, QUIET);
      end
    end

    // wind down and report
    in_valid <= 1'b0;
    while (lock_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (bad_beats == 0 && lock_results_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pdlc_pkg.sv
sv/pdlc_core.sv
sv/password_door_lock_controller_top.sv
bench/password_door_lock_controller_top_tb.sv
